// File: sv/tlvx_pkg.sv
package tlvx_pkg;

    // Length field width; record and total lengths are masked to it
    localparam int LENGTH_BITS = 16;
    localparam logic [15:0] LEN_MASK = 16'((17'(1) << LENGTH_BITS) - 17'(1));

    // Record header is type byte plus 16-bit body length
    localparam logic [15:0] HEADER_LEN = 16'd3;
    // First record starts right after the 2-byte total length
    localparam logic [15:0] RECORD_START_INIT = 16'd2;

    localparam logic [7:0] TYPE_STRING  = 8'd1;
    localparam logic [7:0] TYPE_INTEGER = 8'd2;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_OVERRUN  = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;

    // One result item
    typedef struct packed {
        logic [7:0]  body_byte;
        logic [31:0] int_value;
        logic [2:0]  status;
        logic        final_result;
    } t_result;

endpackage

// File: sv/tlvx_parser.sv
// Per-byte message parser: state registers plus next-state and result logic.
module tlvx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    input  logic [15:0]       i_available_length,
    input  logic [7:0]        i_skip_count,
    input  logic              i_want_integer,
    output logic              o_res_valid,
    output tlvx_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TOTAL,
        PH_HEADER,
        PH_BODY,
        PH_DONE
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [15:0] r_pos,        n_pos;
    logic [15:0] r_decl,       n_decl;
    logic [15:0] r_start,      n_start;
    logic [15:0] r_rlen,       n_rlen;
    logic [7:0]  r_rtype,      n_rtype;
    logic [7:0]  r_skips,      n_skips;
    logic        r_int_mode,   n_int_mode;
    logic [15:0] r_buf_size,   n_buf_size;
    logic [31:0] r_acc,        n_acc;

    // Next state and result for the byte being transferred
    always_comb begin
        logic        active;
        logic [15:0] p;
        logic [15:0] k;
        logic [15:0] len_v;
        logic [15:0] next_start;
        logic        last_body;
        logic [7:0]  want_type;

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_decl     = r_decl;
        n_start    = r_start;
        n_rlen     = r_rlen;
        n_rtype    = r_rtype;
        n_skips    = r_skips;
        n_int_mode = r_int_mode;
        n_buf_size = r_buf_size;
        n_acc      = r_acc;
        o_res_valid = 1'b0;
        o_res       = '0;
        active      = 1'b0;
        p           = '0;
        k           = '0;
        len_v       = '0;
        next_start  = '0;
        last_body   = 1'b0;
        want_type   = '0;

        if (i_accept) begin
            if (i_first_byte) begin
                // Sample request and restart the message
                n_buf_size = i_available_length;
                n_skips    = i_skip_count;
                n_int_mode = i_want_integer;
                n_pos      = '0;
                n_decl     = '0;
                n_start    = tlvx_pkg::RECORD_START_INIT;
                n_rlen     = '0;
                n_rtype    = '0;
                n_acc      = '0;
                if (i_available_length <= tlvx_pkg::HEADER_LEN - 16'd1) begin
                    o_res_valid        = 1'b1;
                    o_res.status       = tlvx_pkg::ST_EMPTY;
                    o_res.final_result = 1'b1;
                    n_phase            = PH_DONE;
                end else begin
                    n_phase = PH_TOTAL;
                    active  = 1'b1;
                end
            end else begin
                active = (r_phase == PH_TOTAL) || (r_phase == PH_HEADER) ||
                         (r_phase == PH_BODY);
            end
        end

        if (active) begin
            p         = n_pos;
            want_type = n_int_mode ? tlvx_pkg::TYPE_INTEGER : tlvx_pkg::TYPE_STRING;
            unique case (n_phase)
                PH_TOTAL: begin
                    if (p == 16'd0) begin
                        n_decl = {i_data_byte, 8'd0};
                    end else begin
                        len_v  = (n_decl | {8'd0, i_data_byte}) & tlvx_pkg::LEN_MASK;
                        n_decl = len_v;
                        if (len_v > n_buf_size) begin
                            o_res_valid        = 1'b1;
                            o_res.status       = tlvx_pkg::ST_BAD_LEN;
                            o_res.final_result = 1'b1;
                            n_phase            = PH_DONE;
                        end else begin
                            n_phase = PH_HEADER;
                            n_start = tlvx_pkg::RECORD_START_INIT;
                        end
                    end
                end
                PH_HEADER: begin
                    if (p >= n_start) begin
                        k = p - n_start;
                        if (k == 16'd0) begin
                            n_rtype = i_data_byte;
                        end else if (k == 16'd1) begin
                            n_rlen = {i_data_byte, 8'd0};
                        end else begin
                            len_v  = (n_rlen | {8'd0, i_data_byte}) & tlvx_pkg::LEN_MASK;
                            n_rlen = len_v;
                            next_start = n_start + tlvx_pkg::HEADER_LEN + len_v;
                            if (18'(n_start) + 18'(tlvx_pkg::HEADER_LEN) + 18'(len_v) >
                                18'(n_decl)) begin
                                // Record reaches past the declared end
                                o_res_valid        = 1'b1;
                                o_res.status       = tlvx_pkg::ST_OVERRUN;
                                o_res.final_result = 1'b1;
                                n_phase            = PH_DONE;
                            end else if (n_skips != 8'd0) begin
                                n_skips = n_skips - 8'd1;
                                n_start = next_start;
                                if (next_start >= n_decl) begin
                                    o_res_valid        = 1'b1;
                                    o_res.status       = tlvx_pkg::ST_EMPTY;
                                    o_res.final_result = 1'b1;
                                    n_phase            = PH_DONE;
                                end
                            end else if (n_rtype != want_type) begin
                                o_res_valid        = 1'b1;
                                o_res.status       = tlvx_pkg::ST_MISMATCH;
                                o_res.final_result = 1'b1;
                                n_phase            = PH_DONE;
                            end else if (len_v == 16'd0) begin
                                // Empty body: integer zero is fine, empty string is not
                                o_res_valid        = 1'b1;
                                o_res.status       = n_int_mode ? tlvx_pkg::ST_OK
                                                                : tlvx_pkg::ST_EMPTY;
                                o_res.final_result = 1'b1;
                                n_phase            = PH_DONE;
                            end else begin
                                n_acc   = '0;
                                n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    k         = p - n_start - tlvx_pkg::HEADER_LEN;
                    last_body = (17'(k) + 17'd1) >= 17'(n_rlen);
                    if (!n_int_mode) begin
                        o_res_valid        = 1'b1;
                        o_res.body_byte    = i_data_byte;
                        o_res.status       = tlvx_pkg::ST_OK;
                        o_res.final_result = last_body;
                        if (last_body) begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        // Big-endian; bodies over four bytes keep the first three
                        if (k == 16'd0) begin
                            n_acc = {24'd0, i_data_byte};
                        end else if ((k == 16'd1) || (k == 16'd2) ||
                                     ((k == 16'd3) && (n_rlen == 16'd4))) begin
                            n_acc = {n_acc[23:0], i_data_byte};
                        end
                        if (last_body) begin
                            o_res_valid        = 1'b1;
                            o_res.int_value    = n_acc;
                            o_res.status       = tlvx_pkg::ST_OK;
                            o_res.final_result = 1'b1;
                            n_phase            = PH_DONE;
                        end
                    end
                end
                PH_IDLE, PH_DONE: begin
                end
                default: begin
                end
            endcase

            // Data ran out before the message finished
            if ((n_phase != PH_DONE) &&
                (i_last_byte || ((17'(p) + 17'd1) >= 17'(n_buf_size)))) begin
                o_res_valid        = 1'b1;
                o_res              = '0;
                o_res.status       = tlvx_pkg::ST_OVERRUN;
                o_res.final_result = 1'b1;
                n_phase            = PH_DONE;
            end

            // Saturating byte counter
            n_pos = (p == 16'hFFFF) ? p : p + 16'd1;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_decl     <= '0;
            r_start    <= tlvx_pkg::RECORD_START_INIT;
            r_rlen     <= '0;
            r_rtype    <= '0;
            r_skips    <= '0;
            r_int_mode <= 1'b0;
            r_buf_size <= '0;
            r_acc      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_decl     <= n_decl;
            r_start    <= n_start;
            r_rlen     <= n_rlen;
            r_rtype    <= n_rtype;
            r_skips    <= n_skips;
            r_int_mode <= n_int_mode;
            r_buf_size <= n_buf_size;
            r_acc      <= n_acc;
        end
    end

endmodule

// File: sv/tlv_record_extractor_top.sv
// A result passes from the parser into the output register, or into the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is free; the parser state updates once per byte.
// An output register plus one skid entry let bytes keep flowing while a result waits.
// Reset: synchronous, active low; parser goes idle and both output entries empty.
// After reset, bytes without first_byte are dropped until a message starts.
module tlv_record_extractor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_available_length,
    input  logic [7:0]  i_skip_count,
    input  logic        i_want_integer,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_body_byte,
    output logic [31:0] o_int_value,
    output logic [2:0]  o_status,
    output logic        o_final_result
);

    logic              accept;
    logic              res_valid;
    tlvx_pkg::t_result res;

    logic              r_out_valid;
    tlvx_pkg::t_result r_out;
    logic              r_skid_valid;
    tlvx_pkg::t_result r_skid;

    // Input transfers whenever the skid entry is free
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;

    tlvx_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_first_byte       (i_first_byte),
        .i_last_byte        (i_last_byte),
        .i_available_length (i_available_length),
        .i_skip_count       (i_skip_count),
        .i_want_integer     (i_want_integer),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                    r_out       <= res;
                end
            end else if (res_valid) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_body_byte    = r_out.body_byte;
    assign o_int_value    = r_out.int_value;
    assign o_status       = r_out.status;
    assign o_final_result = r_out.final_result;

endmodule
